[rtl/core/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Types, codes and constants shared by the bank switch mapper files.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  localparam int unsigned WORK_RAM_BYTES = 8192;
  localparam int unsigned WRAM_AW        = $clog2(WORK_RAM_BYTES);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned TGT_W    = 3;
  localparam int unsigned MADDR_W  = 19;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] TIMEOUT_DEFAULT = 11'd1784;
  localparam logic [DATA_W-1:0]  NT_ROM_PAGE_BIT = 8'h80;
  localparam logic [ADDR_W-1:0]  WRAM_BASE       = 16'h6000;
  localparam logic [ADDR_W-1:0]  TIMER_CLEAR_ADDR = 16'h6000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_PPU_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_NONE    = 3'd0,
    TGT_WRAM    = 3'd1,
    TGT_MAIN    = 3'd2,
    TGT_OPTION  = 3'd3,
    TGT_CHR     = 3'd4,
    TGT_CIRAM   = 3'd5
  } target_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPTION_PRESENT = 3'd0,
    CFG_CHR_IS_RAM     = 3'd1,
    CFG_PRG_MASK       = 3'd2,
    CFG_OPTION_MASK    = 3'd3,
    CFG_CHR_2K_MASK    = 3'd4,
    CFG_CHR_1K_MASK    = 3'd5,
    CFG_TIMEOUT        = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    MIRROR_VERTICAL   = 2'd0,
    MIRROR_HORIZONTAL = 2'd1,
    MIRROR_SINGLE_0   = 2'd2,
    MIRROR_SINGLE_1   = 2'd3
  } mirror_t;

  typedef struct packed {
    logic                option_rom_present;
    logic                chr_is_ram;
    logic [3:0]          prg_bank_mask;
    logic [2:0]          option_bank_mask;
    logic [7:0]          chr_2k_mask;
    logic [7:0]          chr_1k_mask;
    logic [COUNT_W-1:0]  option_timeout_reads;
  } cfg_t;

  typedef struct packed {
    logic [3:0][7:0]     pattern_banks;
    logic [1:0][7:0]     nametable_pages;
    logic                nt_from_rom;
    mirror_t             mirroring;
    logic [2:0]          program_bank;
    logic                option_selected;
    logic [COUNT_W-1:0]  read_count;
    logic                timed_out;
  } map_state_t;

endpackage

`default_nettype wire

[rtl/core/bsm_if.sv]
// ----------------------------------------------------------------------------
// bsm_if
// Valid/ready channels for bus accesses, translations and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsm_item_if;
  logic                      valid;
  logic                      ready;
  logic [bsm_pkg::CMD_W-1:0]  command;
  logic [bsm_pkg::ADDR_W-1:0] bus_address;
  logic [bsm_pkg::DATA_W-1:0] bus_data;

  modport source (output valid, command, bus_address, bus_data, input ready);
  modport sink   (input valid, command, bus_address, bus_data, output ready);
endinterface

interface bsm_result_if;
  logic                       valid;
  logic                       ready;
  logic [bsm_pkg::TGT_W-1:0]   target;
  logic [bsm_pkg::MADDR_W-1:0] mem_address;
  logic                       write_enable;

  modport source (output valid, target, mem_address, write_enable, input ready);
  modport sink   (input valid, target, mem_address, write_enable, output ready);
endinterface

interface bsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsm_pkg::CFG_IDX_W-1:0]  index;
  logic [bsm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/bsm_xlate.sv]
// ----------------------------------------------------------------------------
// bsm_xlate
// Address translation and register update for one bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_xlate (
  input  wire logic [bsm_pkg::CMD_W-1:0]   command,
  input  wire logic [bsm_pkg::ADDR_W-1:0]  bus_address,
  input  wire logic [bsm_pkg::DATA_W-1:0]  bus_data,
  input  wire bsm_pkg::cfg_t               cfg_regs,
  input  wire bsm_pkg::map_state_t         state,
  output bsm_pkg::map_state_t              state_next,
  output bsm_pkg::target_t                 target,
  output logic [bsm_pkg::MADDR_W-1:0]      mem_address,
  output logic                             write_enable
);
  import bsm_pkg::*;

  logic               is_write;
  logic               is_cpu;
  logic [13:0]        ppu_addr;
  logic               nt_sel;
  logic [7:0]         nt_page;
  logic [COUNT_W-1:0] count_inc;
  logic [ADDR_W-1:0]  wram_off;

  assign is_write  = command[0];
  assign is_cpu    = (command == CMD_CPU_READ) || (command == CMD_CPU_WRITE);
  assign ppu_addr  = bus_address[13:0];
  assign count_inc = state.read_count + COUNT_W'(1);
  assign wram_off  = bus_address - WRAM_BASE;

  // Pick the nametable page for the 1KB slot given by address bits 11..10
  always_comb begin
    unique case (state.mirroring)
      MIRROR_VERTICAL:   nt_sel = ppu_addr[10];
      MIRROR_HORIZONTAL: nt_sel = ppu_addr[11];
      MIRROR_SINGLE_0:   nt_sel = 1'b0;
      MIRROR_SINGLE_1:   nt_sel = 1'b1;
      default:           nt_sel = 1'b0;
    endcase
  end

  assign nt_page = (state.nametable_pages[nt_sel] | NT_ROM_PAGE_BIT) & cfg_regs.chr_1k_mask;

  always_comb begin
    state_next   = state;
    target       = TGT_NONE;
    mem_address  = '0;
    write_enable = 1'b0;
    if (is_cpu) begin
      if (bus_address[15]) begin
        if (is_write) begin
          if (!bus_address[14]) begin
            state_next.pattern_banks[bus_address[13:12]] = bus_data;
          end else if (!bus_address[13]) begin
            state_next.nametable_pages[bus_address[12]] = bus_data;
          end else if (!bus_address[12]) begin
            state_next.mirroring   = mirror_t'(bus_data[1:0]);
            state_next.nt_from_rom = bus_data[4];
          end else begin
            state_next.program_bank    = bus_data[2:0];
            state_next.option_selected = ~bus_data[3];
          end
          state_next.timed_out = 1'b0;
        end else if (!bus_address[14]) begin
          // Count window reads, saturating; the read that hits the limit sees main ROM
          if (state.read_count != COUNT_MAX) begin
            state_next.read_count = count_inc;
            if (count_inc == cfg_regs.option_timeout_reads) begin
              state_next.timed_out = 1'b1;
            end
          end
          if (cfg_regs.option_rom_present && state.option_selected &&
              !state_next.timed_out) begin
            target      = TGT_OPTION;
            mem_address = {2'b00, state.program_bank & cfg_regs.option_bank_mask,
                           bus_address[13:0]};
          end else begin
            target      = TGT_MAIN;
            mem_address = {1'b0, {1'b0, state.program_bank} & cfg_regs.prg_bank_mask,
                           bus_address[13:0]};
          end
        end else begin
          target      = TGT_MAIN;
          mem_address = {1'b0, 4'b0111 & cfg_regs.prg_bank_mask, bus_address[13:0]};
        end
      end else if (bus_address[14:13] == 2'b11) begin
        if (is_write && bus_address == TIMER_CLEAR_ADDR && bus_data == '0) begin
          state_next.read_count = '0;
          state_next.timed_out  = 1'b0;
        end
        target       = TGT_WRAM;
        mem_address  = MADDR_W'(wram_off[WRAM_AW-1:0]);
        write_enable = is_write;
      end
    end else begin
      if (!ppu_addr[13]) begin
        target       = TGT_CHR;
        mem_address  = {state.pattern_banks[ppu_addr[12:11]] & cfg_regs.chr_2k_mask,
                        ppu_addr[10:0]};
        write_enable = is_write && cfg_regs.chr_is_ram;
      end else if (ppu_addr[13:8] != 6'h3F) begin
        if (!cfg_regs.chr_is_ram && state.nt_from_rom) begin
          target      = TGT_CHR;
          mem_address = {1'b0, nt_page, ppu_addr[9:0]};
        end else begin
          target       = TGT_CIRAM;
          mem_address  = {8'b0, nt_sel, ppu_addr[9:0]};
          write_enable = is_write;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/bank_switch_mapper_with_license_timer.sv]
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_license_timer
// Bank switching cartridge mapper with option ROM read timeout.
// ----------------------------------------------------------------------------
// An accepted access moves from the input register to the result register.
// Throughput: one access per cycle while results are taken; both registers
// advance together; while a result waits, only an empty input takes an access.
// Reset: rst (synchronous) empties both stages, zeroes the bank state and
// loads the register defaults. Register writes are taken in every cycle.
`default_nettype none

module bank_switch_mapper_with_license_timer (
  input  wire logic    clk,
  input  wire logic    rst,
  bsm_item_if.sink     item,
  bsm_result_if.source result,
  bsm_cfg_if.sink      cfg
);
  import bsm_pkg::*;

  cfg_t                cfg_regs;
  map_state_t          state;
  map_state_t          state_next;

  logic                in_valid;
  logic [CMD_W-1:0]    in_command;
  logic [ADDR_W-1:0]   in_address;
  logic [DATA_W-1:0]   in_data;

  logic                advance;
  target_t             xl_target;
  logic [MADDR_W-1:0]  xl_address;
  logic                xl_we;

  assign advance    = !result.valid || result.ready;
  assign item.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.option_rom_present   <= 1'b0;
      cfg_regs.chr_is_ram           <= 1'b0;
      cfg_regs.prg_bank_mask        <= 4'd7;
      cfg_regs.option_bank_mask     <= 3'd7;
      cfg_regs.chr_2k_mask          <= 8'hFF;
      cfg_regs.chr_1k_mask          <= 8'hFF;
      cfg_regs.option_timeout_reads <= TIMEOUT_DEFAULT;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_OPTION_PRESENT: cfg_regs.option_rom_present   <= cfg.data[0];
        CFG_CHR_IS_RAM:     cfg_regs.chr_is_ram           <= cfg.data[0];
        CFG_PRG_MASK:       cfg_regs.prg_bank_mask        <= cfg.data[3:0];
        CFG_OPTION_MASK:    cfg_regs.option_bank_mask     <= cfg.data[2:0];
        CFG_CHR_2K_MASK:    cfg_regs.chr_2k_mask          <= cfg.data[7:0];
        CFG_CHR_1K_MASK:    cfg_regs.chr_1k_mask          <= cfg.data[7:0];
        CFG_TIMEOUT:        cfg_regs.option_timeout_reads <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_command <= item.command;
      in_address <= item.bus_address;
      in_data    <= item.bus_data;
    end
  end

  bsm_xlate u_xlate (
    .command      (in_command),
    .bus_address  (in_address),
    .bus_data     (in_data),
    .cfg_regs     (cfg_regs),
    .state        (state),
    .state_next   (state_next),
    .target       (xl_target),
    .mem_address  (xl_address),
    .write_enable (xl_we)
  );

  // Commit state only when the access moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      result.valid  <= 1'b0;
    end else if (in_valid && advance) begin
      state         <= state_next;
      result.valid  <= 1'b1;
    end else if (result.ready) begin
      result.valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      result.target       <= xl_target;
      result.mem_address  <= xl_address;
      result.write_enable <= xl_we;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsm_checker.sv]
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks on the mapper's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [bsm_pkg::TGT_W-1:0]    out_target,
  input wire logic [bsm_pkg::MADDR_W-1:0]  out_address,
  input wire logic                         out_we
);
  import bsm_pkg::*;

  // No result may appear straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid in cycle after reset");

  // An unmapped access carries a zero offset and no write
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_target == TGT_NONE) |-> (out_address == '0 && !out_we))
    else $error("unmapped access with address or write");

  // Program ROM is never written
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_target == TGT_MAIN || out_target == TGT_OPTION)) |-> !out_we)
    else $error("write enable on program ROM");

  // Console nametable RAM is only 2KB
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_target == TGT_CIRAM) |-> (out_address[MADDR_W-1:11] == '0))
    else $error("nametable RAM offset out of range");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_target) &&
                                   $stable(out_address) && $stable(out_we)))
    else $error("stalled result changed");

endmodule

bind bank_switch_mapper_with_license_timer bsm_checker u_bsm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_target  (result.target),
  .out_address (result.mem_address),
  .out_we      (result.write_enable)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bank switch mapper one bus access at a time. A directed table
// covers the address map edges, then random register programming, timer runs
// and noise follow under several register settings. Every translation is
// compared against a typed expectation or a local model of the mapper state,
// with bursty input and a stalling result side.
// ----------------------------------------------------------------------------

module testbench;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    target_t              tgt;
    logic [MADDR_W-1:0]   addr;
    logic                 we;
  } translation_t;

  typedef struct {
    cmd_t                 cmd;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    data;
    bit                   typed;
    translation_t         want;
  } access_row_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst;

  bsm_item_if   item_ch ();
  bsm_result_if result_ch ();
  bsm_cfg_if    cfg_ch ();

  bank_switch_mapper_with_license_timer i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Mapper model: bank state and register settings
  map_state_t   map_model;
  cfg_t         cfg_model;
  translation_t due_translations[$];

  int accesses_sent;
  int results_checked;
  int mismatches;
  int settings_applied;
  int option_hits;
  int timer_expiries;
  int burst_left;
  int hold_requests;
  int holds_served;
  int cycles;

  // Expectations are typed in only where the answer is plain from the map.
  access_row_t directed_rows [25] = '{
    '{CMD_CPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_CPU_WRITE, 16'h5FFF, 8'hFF, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_CPU_READ,  16'h6000, 8'h00, 1'b1, '{TGT_WRAM,  19'h00000, 1'b0}},
    '{CMD_CPU_WRITE, 16'h7FFF, 8'hAA, 1'b1, '{TGT_WRAM,  19'h01FFF, 1'b1}},
    '{CMD_CPU_READ,  16'h8000, 8'h00, 1'b1, '{TGT_MAIN,  19'h00000, 1'b0}},
    '{CMD_CPU_READ,  16'hFFFF, 8'h00, 1'b1, '{TGT_MAIN,  19'h1FFFF, 1'b0}},
    '{CMD_CPU_WRITE, 16'h8000, 8'hFF, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_CPU_WRITE, 16'hB000, 8'h01, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_PPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_CHR,   19'h7F800, 1'b0}},
    '{CMD_PPU_WRITE, 16'h1FFF, 8'h55, 1'b1, '{TGT_CHR,   19'h00FFF, 1'b0}},
    '{CMD_CPU_WRITE, 16'hC000, 8'h12, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_CPU_WRITE, 16'hD000, 8'h7F, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_PPU_WRITE, 16'h2400, 8'h33, 1'b1, '{TGT_CIRAM, 19'h00400, 1'b1}},
    '{CMD_PPU_READ,  16'h3F00, 8'h00, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_PPU_WRITE, 16'hFFFF, 8'hFF, 1'b1, '{TGT_NONE,  19'h00000, 1'b0}},
    '{CMD_CPU_WRITE, 16'hE000, 8'h11, 1'b0, '0},
    '{CMD_PPU_READ,  16'h2C05, 8'h00, 1'b0, '0},
    '{CMD_PPU_WRITE, 16'h3000, 8'h9C, 1'b0, '0},
    '{CMD_CPU_WRITE, 16'hE000, 8'h02, 1'b0, '0},
    '{CMD_PPU_WRITE, 16'h2800, 8'h44, 1'b0, '0},
    '{CMD_CPU_WRITE, 16'hF000, 8'h05, 1'b0, '0},
    '{CMD_CPU_READ,  16'hBFFF, 8'h00, 1'b0, '0},
    '{CMD_CPU_WRITE, 16'h6000, 8'h00, 1'b0, '0},
    '{CMD_CPU_WRITE, 16'hEFFF, 8'h13, 1'b0, '0},
    '{CMD_PPU_READ,  16'h3EFF, 8'h00, 1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d translations outstanding",
               cycles, due_translations.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Work out one translation and advance the model state with it.
  function automatic translation_t translate_access(input cmd_t c,
                                                    input logic [ADDR_W-1:0] a,
                                                    input logic [DATA_W-1:0] d);
    translation_t r;
    logic [13:0]  pa;
    logic         sel;
    logic [2:0]   bank;
    bit           wr;
    r  = '0;
    r.tgt = TGT_NONE;
    wr = (c == CMD_CPU_WRITE) || (c == CMD_PPU_WRITE);
    pa = a[13:0];
    if (c == CMD_CPU_READ || c == CMD_CPU_WRITE) begin
      if (a >= 16'h8000) begin
        if (wr) begin
          if (a < 16'hC000) begin
            map_model.pattern_banks[a[13:12]] = d;
          end else if (a < 16'hE000) begin
            map_model.nametable_pages[a[12]] = d;
          end else if (a[15:12] == 4'hE) begin
            map_model.mirroring   = mirror_t'(d[1:0]);
            map_model.nt_from_rom = d[4];
          end else begin
            map_model.program_bank    = d[2:0];
            map_model.option_selected = ~d[3];
          end
          map_model.timed_out = 1'b0;
        end else if (a < 16'hC000) begin
          if (map_model.read_count != COUNT_MAX) begin
            map_model.read_count = map_model.read_count + 1'b1;
            if (map_model.read_count == cfg_model.option_timeout_reads) begin
              map_model.timed_out = 1'b1;
              timer_expiries++;
            end
          end
          if (cfg_model.option_rom_present && map_model.option_selected &&
              !map_model.timed_out) begin
            bank  = map_model.program_bank & cfg_model.option_bank_mask;
            r.tgt = TGT_OPTION;
            option_hits++;
          end else begin
            bank  = map_model.program_bank & cfg_model.prg_bank_mask[2:0];
            r.tgt = TGT_MAIN;
          end
          r.addr = {2'b00, bank, a[13:0]};
        end else begin
          // fixed upper window: last main bank
          bank   = 3'h7 & cfg_model.prg_bank_mask[2:0];
          r.tgt  = TGT_MAIN;
          r.addr = {2'b00, bank, a[13:0]};
        end
      end else if (a >= WRAM_BASE) begin
        if (c == CMD_CPU_WRITE && a == TIMER_CLEAR_ADDR && d == '0) begin
          map_model.read_count = '0;
          map_model.timed_out  = 1'b0;
        end
        r.tgt  = TGT_WRAM;
        r.addr = MADDR_W'(a[WRAM_AW-1:0]);
        r.we   = wr;
      end
    end else if (pa < 14'h2000) begin
      r.tgt  = TGT_CHR;
      r.addr = {map_model.pattern_banks[pa[12:11]] & cfg_model.chr_2k_mask, pa[10:0]};
      r.we   = wr && cfg_model.chr_is_ram;
    end else if (pa < 14'h3F00) begin
      case (map_model.mirroring)
        MIRROR_VERTICAL:   sel = pa[10];
        MIRROR_HORIZONTAL: sel = pa[11];
        MIRROR_SINGLE_0:   sel = 1'b0;
        default:           sel = 1'b1;
      endcase
      if (!cfg_model.chr_is_ram && map_model.nt_from_rom) begin
        r.tgt  = TGT_CHR;
        r.addr = {1'b0, (map_model.nametable_pages[sel] | NT_ROM_PAGE_BIT) &
                        cfg_model.chr_1k_mask, pa[9:0]};
      end else begin
        r.tgt  = TGT_CIRAM;
        r.addr = {8'h00, sel, pa[9:0]};
        r.we   = wr;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk) begin : check_results
    translation_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_translations.size() == 0) begin
        report_mismatch($sformatf("unexpected result target %0d address %05h we %0b",
                                  result_ch.target, result_ch.mem_address,
                                  result_ch.write_enable));
      end else begin
        want = due_translations.pop_front();
        if (result_ch.target !== want.tgt || result_ch.mem_address !== want.addr ||
            result_ch.write_enable !== want.we) begin
          report_mismatch($sformatf(
            "result %0d: expected target %0d address %05h we %0b, got %0d %05h %0b",
            results_checked, want.tgt, want.addr, want.we, result_ch.target,
            result_ch.mem_address, result_ch.write_enable));
        end
        results_checked++;
      end
    end
  end

  // Result side: long hold on request, otherwise a changing stall pattern.
  initial begin : result_stalls
    rx_mode_t   mode;
    int         mode_left;
    int         hold_left;
    logic [7:0] mask;
    mode      = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    mask      = 8'hFF;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
          mask      = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (mode)
          RX_STEADY: result_ch.ready <= 1'b1;
          RX_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            result_ch.ready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  // Offer one access and hold it until the transfer, then log its translation.
  task automatic send_access(input cmd_t c, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d, input bit typed,
                             input translation_t want);
    translation_t predicted;
    item_ch.valid       <= 1'b1;
    item_ch.command     <= c;
    item_ch.bus_address <= a;
    item_ch.bus_data    <= d;
    do @(posedge clk); while (!item_ch.ready);
    predicted = translate_access(c, a, d);
    due_translations.push_back(typed ? want : predicted);
    accesses_sent++;
  endtask

  task automatic send_noise();
    send_access(cmd_t'(2'($urandom)), 16'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // Sender bursts: random length, random gaps between them, sometimes none.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (due_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_OPTION_PRESENT: cfg_model.option_rom_present   = val[0];
      CFG_CHR_IS_RAM:     cfg_model.chr_is_ram           = val[0];
      CFG_PRG_MASK:       cfg_model.prg_bank_mask        = val[3:0];
      CFG_OPTION_MASK:    cfg_model.option_bank_mask     = val[2:0];
      CFG_CHR_2K_MASK:    cfg_model.chr_2k_mask          = val[7:0];
      CFG_CHR_1K_MASK:    cfg_model.chr_1k_mask          = val[7:0];
      CFG_TIMEOUT:        cfg_model.option_timeout_reads = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    drain();
    write_setting(CFG_OPTION_PRESENT, CFG_DATA_W'(s.option_rom_present));
    write_setting(CFG_CHR_IS_RAM,     CFG_DATA_W'(s.chr_is_ram));
    write_setting(CFG_PRG_MASK,       CFG_DATA_W'(s.prg_bank_mask));
    write_setting(CFG_OPTION_MASK,    CFG_DATA_W'(s.option_bank_mask));
    write_setting(CFG_CHR_2K_MASK,    CFG_DATA_W'(s.chr_2k_mask));
    write_setting(CFG_CHR_1K_MASK,    CFG_DATA_W'(s.chr_1k_mask));
    write_setting(CFG_TIMEOUT,        CFG_DATA_W'(s.option_timeout_reads));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Mostly well-formed mapper use: bank select plus window reads that run the
  // timer, register writes followed by PPU fetches, work RAM, and some noise.
  task automatic run_traffic(input int n);
    int goal;
    int kind;
    int lim;
    goal = accesses_sent + n;
    while (accesses_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        pace();
        send_access(CMD_CPU_WRITE, {4'hF, 12'($urandom)},
                    {4'($urandom), ($urandom_range(0, 4) == 0), 3'($urandom)}, 1'b0, '0);
        if ($urandom_range(0, 3) != 0) begin
          pace();
          send_access(CMD_CPU_WRITE, TIMER_CLEAR_ADDR, 8'h00, 1'b0, '0);
        end
        lim = (cfg_model.option_timeout_reads > 40) ? 40 :
              int'(cfg_model.option_timeout_reads) + 3;
        repeat ($urandom_range(1, lim)) begin
          pace();
          if ($urandom_range(0, 7) == 0) send_noise();
          else send_access(CMD_CPU_READ, {2'b10, 14'($urandom)}, 8'($urandom), 1'b0, '0);
        end
      end else if (kind <= 6) begin
        pace();
        send_access(CMD_CPU_WRITE, {4'($urandom_range(8, 14)), 12'($urandom)},
                    8'($urandom), 1'b0, '0);
        repeat ($urandom_range(2, 6)) begin
          pace();
          send_access(cmd_t'(2'($urandom_range(2, 3))),
                      {2'($urandom), 14'($urandom_range(0, 16'h3EFF))},
                      8'($urandom), 1'b0, '0);
        end
      end else if (kind == 7) begin
        pace();
        if ($urandom_range(0, 3) == 0)
          send_access(CMD_CPU_WRITE, TIMER_CLEAR_ADDR, 8'h00, 1'b0, '0);
        else
          send_access(cmd_t'({1'b0, 1'($urandom)}), {3'b011, 13'($urandom)},
                      8'($urandom), 1'b0, '0);
      end else begin
        pace();
        send_noise();
      end
    end
  endtask

  initial begin
    cfg_t s;
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.command     <= CMD_CPU_READ;
    item_ch.bus_address <= '0;
    item_ch.bus_data    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_OPTION_PRESENT;
    cfg_ch.data         <= '0;
    map_model = '0;
    cfg_model = '{1'b0, 1'b0, 4'd7, 3'd7, 8'hFF, 8'hFF, TIMEOUT_DEFAULT};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace();
      send_access(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Option ROM fitted, widest masks, short timeout.
    apply_settings('{1'b1, 1'b0, 4'hF, 3'h7, 8'hFF, 8'hFF, 11'd7});
    // Hold the result side while accesses keep coming, so the input stalls.
    hold_requests++;
    repeat (30) send_noise();
    run_traffic(80);

    // Character RAM, all masks closed, timeout on the first read.
    apply_settings('{1'b1, 1'b1, 4'h0, 3'h0, 8'h00, 8'h00, 11'd1});
    run_traffic(60);

    // Long timeout: a run of window reads that stays well short of it.
    apply_settings('{1'b1, 1'b0, 4'h5, 3'h3, 8'h55, 8'hAA, 11'd2046});
    pace();
    send_access(CMD_CPU_WRITE, 16'hF000, 8'h00, 1'b0, '0);
    pace();
    send_access(CMD_CPU_WRITE, TIMER_CLEAR_ADDR, 8'h00, 1'b0, '0);
    repeat (60) begin
      pace();
      send_access(CMD_CPU_READ, {2'b10, 14'($urandom)}, 8'($urandom), 1'b0, '0);
    end
    run_traffic(30);

    // Timeout below the count left by the long run; no option ROM fitted.
    apply_settings('{1'b0, 1'b0, 4'hA, 3'h5, 8'hF0, 8'h0F, 11'd20});
    run_traffic(60);

    s.option_rom_present   = 1'b1;
    s.chr_is_ram           = 1'($urandom);
    s.prg_bank_mask        = 4'($urandom);
    s.option_bank_mask     = 3'($urandom);
    s.chr_2k_mask          = 8'($urandom);
    s.chr_1k_mask          = 8'($urandom);
    s.option_timeout_reads = 11'($urandom_range(1, 30));
    apply_settings(s);
    run_traffic(60);

    drain();
    $display("Covered %0d accesses under %0d register settings: %0d translations checked,",
             accesses_sent, settings_applied + 1, results_checked);
    $display("%0d option ROM window hits, %0d timer expiries, %0d mismatches.",
             option_hits, timer_expiries, mismatches);
    if (mismatches == 0 && due_translations.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bsm_pkg.sv
rtl/core/bsm_if.sv
rtl/core/bsm_xlate.sv
rtl/core/bank_switch_mapper_with_license_timer.sv
rtl/core/bsm_checker.sv
tb/testbench.sv
